/* hw/rtl/peu_pkg.sv */
// ----------------------------------------------------------------------------
// peu_pkg
// Shared types and constants of the particle emitter update block.
// ----------------------------------------------------------------------------
package peu_pkg;

   localparam int TABLE_DEPTH   = 64;
   localparam int IDX_W         = 6;
   localparam int PARTICLES_DEF = 64;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DIV_STEPS     = 9;
   localparam int ALPHA_MAX     = 204;
   localparam int CFG_W         = 48;
   localparam int CSR_IDX_W     = 3;
   localparam int VEL_W         = 48;
   localparam int ENT_W         = 159;

   localparam logic [30:0] MOVE_SPEED_RST   = 31'd65536;
   localparam logic [30:0] BASE_SIZE_RST    = 31'd65536;
   localparam logic [30:0] GROW_RATE_RST    = 31'd0;
   localparam logic [30:0] LIFE_SPAN_RST    = 31'd65536;
   localparam logic [30:0] STAGGER_STEP_RST = 31'd1024;
   localparam logic [47:0] ROT_ROW0_RST     = 48'h0000_0000_4000;
   localparam logic [47:0] ROT_ROW1_RST     = 48'h0000_4000_0000;
   localparam logic [47:0] ROT_ROW2_RST     = 48'h4000_0000_0000;

   typedef enum logic [1:0] {
      FUNC_TICK,
      FUNC_TOGGLE,
      FUNC_LOAD,
      FUNC_RESTART
   } func_type;

   typedef enum logic [2:0] {
      CSR_MOVE_SPEED,
      CSR_BASE_SIZE,
      CSR_GROW_RATE,
      CSR_LIFE_SPAN,
      CSR_STAGGER_STEP,
      CSR_ROT_ROW0,
      CSR_ROT_ROW1,
      CSR_ROT_ROW2
   } csr_index_type;

   typedef struct packed {
      func_type           func;
      logic [15:0]        step_time;
      logic [IDX_W-1:0]   slot;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   typedef struct packed {
      logic [30:0] move_speed;
      logic [30:0] base_size;
      logic [30:0] grow_rate;
      logic [30:0] life_span;
      logic [30:0] stagger_step;
      logic [47:0] rot_row0;
      logic [47:0] rot_row1;
      logic [47:0] rot_row2;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        size;
      logic signed [31:0] age;
   } ent_type;

   typedef struct packed {
      logic [IDX_W-1:0]   id;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [30:0]        size;
      logic [7:0]         alpha;
   } res_type;

   typedef enum logic [1:0] {
      CLS_WAIT,
      CLS_LIVE,
      CLS_EXP
   } cls_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PREP,
      B_RD,
      B_EVAL,
      B_UPD,
      B_ROT,
      B_DIV,
      B_NEXT,
      B_FLUSH,
      B_RESTART
   } back_state_type;

endpackage

/* hw/rtl/peu_ram.sv */
// ----------------------------------------------------------------------------
// peu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module peu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* hw/rtl/peu_front.sv */
// ----------------------------------------------------------------------------
// peu_front
// Accepts requests, tags their function and queues them for the back end.
// ----------------------------------------------------------------------------
module peu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_step_time,
   input  logic [5:0]         req_slot,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_vel_z,
   output peu_pkg::queue_type q_out,
   input  logic               q_pop
);

   peu_pkg::cmd_type mem_ff [peu_pkg::QUEUE_DEPTH];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   peu_pkg::cmd_type cmd;

   always_comb begin
      cmd.func      = peu_pkg::func_type'(req_func);
      cmd.step_time = req_step_time;
      cmd.slot      = req_slot;
      cmd.vel_x     = req_vel_x;
      cmd.vel_y     = req_vel_y;
      cmd.vel_z     = req_vel_z;
   end

   assign busy        = (cnt_ff == 2'(peu_pkg::QUEUE_DEPTH));
   assign push        = start && !busy;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.cmd   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = (q_pop && q_out.valid) ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop && q_out.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= cmd;
      end
   end

endmodule

/* hw/rtl/peu_back.sv */
// ----------------------------------------------------------------------------
// peu_back
// Executes queued requests: walks the particle table on a tick, refills it on
// a restart, toggles emitting, loads velocity; emits one result per shown one.
// ----------------------------------------------------------------------------
module peu_back #(
   parameter int PARTICLES = peu_pkg::PARTICLES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  peu_pkg::queue_type        q_in,
   output logic                      q_pop,
   input  peu_pkg::cfg_type          cfg,
   output logic                      rsp_valid,
   output peu_pkg::res_type          rsp,
   output logic                      rsp_last
);

   localparam logic [peu_pkg::IDX_W-1:0] LAST_IDX = peu_pkg::IDX_W'(PARTICLES - 1);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   peu_pkg::back_state_type     state_ff, state_in;
   logic [peu_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        emit_ff, emit_in;
   logic [peu_pkg::TABLE_DEPTH-1:0] vld_ff, vld_in;
   logic signed [31:0]          wacc_ff, wacc_in;
   logic [15:0]                 dt_ff, dt_in;
   logic [46:0]                 spd_ff, spd_in;
   logic [31:0]                 grow_ff, grow_in;
   peu_pkg::cls_type            cls_ff, cls_in;
   peu_pkg::ent_type            ent_ff, ent_in;
   logic signed [63:0]          mprod_ff [3];
   logic signed [63:0]          mprod_in [3];
   logic [1:0]                  rcnt_ff, rcnt_in;
   logic signed [47:0]          rprod_ff [3];
   logic signed [47:0]          rprod_in [3];
   logic signed [31:0]          resv_ff [3];
   logic signed [31:0]          resv_in [3];
   logic [40:0]                 rem_ff, rem_in;
   logic [38:0]                 dvs_ff, dvs_in;
   logic [3:0]                  dcnt_ff, dcnt_in;
   logic [8:0]                  quo_ff, quo_in;
   logic                        azero_ff, azero_in;
   peu_pkg::res_type            pend_ff, pend_in;
   logic                        pend_vld_ff, pend_vld_in;
   peu_pkg::res_type            out_ff, out_in;
   logic                        out_vld_ff, out_vld_in;
   logic                        out_last_ff, out_last_in;

   logic                        st_we;
   peu_pkg::ent_type            st_wdata;
   logic [peu_pkg::ENT_W-1:0]   st_rdata;
   logic                        vel_we;
   logic [peu_pkg::VEL_W-1:0]   vel_wdata;
   logic [peu_pkg::VEL_W-1:0]   vel_rdata;
   logic                        rd_en;

   logic signed [33:0]          wnext;
   logic signed [31:0]          wclamp;
   logic signed [31:0]          wfirst;
   logic signed [31:0]          life_s;
   peu_pkg::ent_type            rd_ent;
   peu_pkg::ent_type            nxt;
   logic                        show;
   logic signed [32:0]          diff;
   logic [40:0]                 num;
   logic signed [63:0]          sh;
   logic signed [31:0]          dlt;
   logic signed [31:0]          pos_old [3];
   logic signed [31:0]          pos_new [3];
   logic signed [15:0]          vel_c [3];
   logic [32:0]                 gsum;
   logic [47:0]                 row;
   logic signed [63:0]          acc;
   logic [7:0]                  alpha;
   peu_pkg::res_type            res;

   peu_ram #(.WIDTH(peu_pkg::ENT_W), .DEPTH(peu_pkg::TABLE_DEPTH)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (idx_ff),
      .wr_data (st_wdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (st_rdata)
   );

   peu_ram #(.WIDTH(peu_pkg::VEL_W), .DEPTH(peu_pkg::TABLE_DEPTH)) u_vel_ram (
      .clock   (clock),
      .wr_en   (vel_we),
      .wr_addr (q_in.cmd.slot),
      .wr_data (vel_wdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (vel_rdata)
   );

   assign wfirst    = -$signed({1'b0, cfg.stagger_step});
   assign wnext     = 34'(wacc_ff) - $signed({3'b000, cfg.stagger_step});
   assign wclamp    = (wnext < -34'sd2147483648) ? 32'sh8000_0000 : wnext[31:0];
   assign life_s    = $signed({1'b0, cfg.life_span});
   assign rd_ent    = vld_ff[idx_ff] ? peu_pkg::ent_type'(st_rdata) : '0;
   assign vel_wdata = {q_in.cmd.vel_z, q_in.cmd.vel_y, q_in.cmd.vel_x};
   assign vel_c[0]  = $signed(vel_rdata[15:0]);
   assign vel_c[1]  = $signed(vel_rdata[31:16]);
   assign vel_c[2]  = $signed(vel_rdata[47:32]);
   assign pos_old[0] = ent_ff.pos_x;
   assign pos_old[1] = ent_ff.pos_y;
   assign pos_old[2] = ent_ff.pos_z;

   always_comb begin
      unique case (rcnt_ff)
         2'd0:    row = cfg.rot_row0;
         2'd1:    row = cfg.rot_row1;
         default: row = cfg.rot_row2;
      endcase
   end

   always_comb begin
      alpha = azero_ff ? 8'd0 :
              (quo_ff > 9'(peu_pkg::ALPHA_MAX)) ? 8'(peu_pkg::ALPHA_MAX) : quo_ff[7:0];
      res.id    = idx_ff;
      res.x     = resv_ff[0];
      res.y     = resv_ff[1];
      res.z     = resv_ff[2];
      res.size  = ent_ff.size;
      res.alpha = alpha;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      emit_in     = emit_ff;
      vld_in      = vld_ff;
      wacc_in     = wacc_ff;
      dt_in       = dt_ff;
      spd_in      = spd_ff;
      grow_in     = grow_ff;
      cls_in      = cls_ff;
      ent_in      = ent_ff;
      mprod_in    = mprod_ff;
      rcnt_in     = rcnt_ff;
      rprod_in    = rprod_ff;
      resv_in     = resv_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      dcnt_in     = dcnt_ff;
      quo_in      = quo_ff;
      azero_in    = azero_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_vld_in  = 1'b0;
      out_last_in = 1'b0;
      st_we       = 1'b0;
      st_wdata    = ent_ff;
      vel_we      = 1'b0;
      rd_en       = 1'b0;
      q_pop       = 1'b0;
      nxt         = ent_ff;
      show        = 1'b0;
      diff        = '0;
      num         = '0;
      sh          = '0;
      dlt         = '0;
      pos_new     = pos_old;
      gsum        = '0;
      acc         = '0;

      if (dcnt_ff != 4'd0) begin
         if (rem_ff >= 41'(dvs_ff)) begin
            rem_in = rem_ff - 41'(dvs_ff);
            quo_in = {quo_ff[7:0], 1'b1};
         end else begin
            quo_in = {quo_ff[7:0], 1'b0};
         end
         dvs_in  = dvs_ff >> 1;
         dcnt_in = dcnt_ff - 4'd1;
      end

      unique case (state_ff)
         peu_pkg::B_IDLE: begin
            if (q_in.valid) begin
               q_pop = 1'b1;
               unique case (q_in.cmd.func)
                  peu_pkg::FUNC_TICK: begin
                     dt_in    = q_in.cmd.step_time;
                     idx_in   = '0;
                     wacc_in  = wfirst;
                     state_in = peu_pkg::B_PREP;
                  end
                  peu_pkg::FUNC_TOGGLE: begin
                     emit_in = !emit_ff;
                  end
                  peu_pkg::FUNC_LOAD: begin
                     vel_we = ({1'b0, q_in.cmd.slot} < 7'(PARTICLES));
                  end
                  peu_pkg::FUNC_RESTART: begin
                     idx_in   = '0;
                     wacc_in  = wfirst;
                     state_in = peu_pkg::B_RESTART;
                  end
               endcase
            end
         end
         peu_pkg::B_PREP: begin
            spd_in   = cfg.move_speed * dt_ff;
            grow_in  = 32'((48'(cfg.grow_rate) * 48'(dt_ff) + 48'd32768) >> 16);
            state_in = peu_pkg::B_RD;
         end
         peu_pkg::B_RD: begin
            rd_en    = 1'b1;
            state_in = peu_pkg::B_EVAL;
         end
         peu_pkg::B_EVAL: begin
            ent_in = rd_ent;
            if (rd_ent.age < 32'sd0) begin
               cls_in = peu_pkg::CLS_WAIT;
            end else if (rd_ent.age < life_s) begin
               cls_in = peu_pkg::CLS_LIVE;
            end else begin
               cls_in = peu_pkg::CLS_EXP;
            end
            for (int c = 0; c < 3; c++) begin
               mprod_in[c] = vel_c[c] * $signed({1'b0, spd_ff});
            end
            state_in = peu_pkg::B_UPD;
         end
         peu_pkg::B_UPD: begin
            unique case (cls_ff)
               peu_pkg::CLS_WAIT: begin
                  nxt.age = ent_ff.age + $signed({16'd0, dt_ff});
                  st_we   = emit_ff;
               end
               peu_pkg::CLS_LIVE: begin
                  for (int c = 0; c < 3; c++) begin
                     sh         = (mprod_ff[c] + 64'sd1073741824) >>> 31;
                     dlt        = sat32(sh);
                     pos_new[c] = sat32(64'(pos_old[c]) + 64'(dlt));
                  end
                  nxt.pos_x = pos_new[0];
                  nxt.pos_y = pos_new[1];
                  nxt.pos_z = pos_new[2];
                  gsum      = 33'(grow_ff) + 33'(ent_ff.size);
                  nxt.size  = gsum[32:31] != 2'b00 ? 31'h7FFF_FFFF : gsum[30:0];
                  nxt.age   = sat32(64'(ent_ff.age) + 64'(dt_ff));
                  st_we     = 1'b1;
                  show      = 1'b1;
               end
               default: begin
                  nxt.pos_x = '0;
                  nxt.pos_y = '0;
                  nxt.pos_z = '0;
                  nxt.size  = cfg.base_size;
                  nxt.age   = emit_ff ? 32'sd0 : wacc_ff;
                  st_we     = 1'b1;
                  show      = emit_ff;
               end
            endcase
            st_wdata = nxt;
            ent_in   = nxt;
            if (st_we) begin
               vld_in[idx_ff] = 1'b1;
            end
            diff     = 33'(life_s) - 33'(nxt.age);
            num      = 41'(diff[31:0]);
            rem_in   = (num << 9) - (num << 1);
            dvs_in   = 39'(cfg.life_span) << 8;
            dcnt_in  = 4'(peu_pkg::DIV_STEPS);
            quo_in   = '0;
            azero_in = (nxt.age >= life_s);
            rcnt_in  = 2'd0;
            state_in = show ? peu_pkg::B_ROT : peu_pkg::B_NEXT;
         end
         peu_pkg::B_ROT: begin
            if (rcnt_ff != 2'd3) begin
               for (int c = 0; c < 3; c++) begin
                  rprod_in[c] = $signed(row[16*c +: 16]) * pos_old[c];
               end
            end
            if (rcnt_ff != 2'd0) begin
               acc = 64'(rprod_ff[0]) + 64'(rprod_ff[1]) + 64'(rprod_ff[2]) + 64'sd8192;
               resv_in[rcnt_ff - 2'd1] = sat32(acc >>> 14);
            end
            rcnt_in = rcnt_ff + 2'd1;
            if (rcnt_ff == 2'd3) begin
               state_in = peu_pkg::B_DIV;
            end
         end
         peu_pkg::B_DIV: begin
            if (dcnt_ff == 4'd0) begin
               if (pend_vld_ff) begin
                  out_in     = pend_ff;
                  out_vld_in = 1'b1;
               end
               pend_in     = res;
               pend_vld_in = 1'b1;
               state_in    = peu_pkg::B_NEXT;
            end
         end
         peu_pkg::B_NEXT: begin
            wacc_in = wclamp;
            if (idx_ff == LAST_IDX) begin
               state_in = peu_pkg::B_FLUSH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = peu_pkg::B_RD;
            end
         end
         peu_pkg::B_FLUSH: begin
            if (pend_vld_ff) begin
               out_in      = pend_ff;
               out_vld_in  = 1'b1;
               out_last_in = 1'b1;
            end
            pend_vld_in = 1'b0;
            state_in    = peu_pkg::B_IDLE;
         end
         peu_pkg::B_RESTART: begin
            st_wdata.pos_x = '0;
            st_wdata.pos_y = '0;
            st_wdata.pos_z = '0;
            st_wdata.size  = cfg.base_size;
            st_wdata.age   = wacc_ff;
            st_we          = 1'b1;
            vld_in[idx_ff] = 1'b1;
            wacc_in        = wclamp;
            if (idx_ff == LAST_IDX) begin
               state_in = peu_pkg::B_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = peu_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= peu_pkg::B_IDLE;
         idx_ff      <= '0;
         emit_ff     <= 1'b1;
         vld_ff      <= '0;
         dcnt_ff     <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         emit_ff     <= emit_in;
         vld_ff      <= vld_in;
         dcnt_ff     <= dcnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      wacc_ff  <= wacc_in;
      dt_ff    <= dt_in;
      spd_ff   <= spd_in;
      grow_ff  <= grow_in;
      cls_ff   <= cls_in;
      ent_ff   <= ent_in;
      mprod_ff <= mprod_in;
      rcnt_ff  <= rcnt_in;
      rprod_ff <= rprod_in;
      resv_ff  <= resv_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      azero_ff <= azero_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

/* hw/rtl/particle_emitter_update.sv */
// ----------------------------------------------------------------------------
// particle_emitter_update
// Toggle and velocity load are handled in the back end's idle state, restart
// writes every particle in turn, and a tick runs each particle through the
// per-particle sequencer, with rotation and the 9-step alpha divider only for
// a shown one. One request runs at a time; two more can queue.
// Results come as one-cycle strobes; the receiver cannot stall.
// Synchronous reset clears the table, sets emitting and loads register defaults.
// ----------------------------------------------------------------------------
module particle_emitter_update #(
   parameter int PARTICLES = peu_pkg::PARTICLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [15:0]                   req_step_time,
   input  logic [5:0]                    req_slot,
   input  logic signed [15:0]            req_vel_x,
   input  logic signed [15:0]            req_vel_y,
   input  logic signed [15:0]            req_vel_z,
   output logic                          rsp_valid,
   output logic [5:0]                    rsp_particle_id,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic [30:0]                   rsp_out_size,
   output logic [7:0]                    rsp_alpha,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [peu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [peu_pkg::CFG_W-1:0]     csr_wdata
);

   peu_pkg::cfg_type   cfg_ff, cfg_in;
   peu_pkg::queue_type q;
   logic               q_pop;
   peu_pkg::res_type   rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (peu_pkg::csr_index_type'(csr_index))
            peu_pkg::CSR_MOVE_SPEED:   cfg_in.move_speed   = csr_wdata[30:0];
            peu_pkg::CSR_BASE_SIZE:    cfg_in.base_size    = csr_wdata[30:0];
            peu_pkg::CSR_GROW_RATE:    cfg_in.grow_rate    = csr_wdata[30:0];
            peu_pkg::CSR_LIFE_SPAN:    cfg_in.life_span    = csr_wdata[30:0];
            peu_pkg::CSR_STAGGER_STEP: cfg_in.stagger_step = csr_wdata[30:0];
            peu_pkg::CSR_ROT_ROW0:     cfg_in.rot_row0     = csr_wdata;
            peu_pkg::CSR_ROT_ROW1:     cfg_in.rot_row1     = csr_wdata;
            peu_pkg::CSR_ROT_ROW2:     cfg_in.rot_row2     = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_speed   <= peu_pkg::MOVE_SPEED_RST;
         cfg_ff.base_size    <= peu_pkg::BASE_SIZE_RST;
         cfg_ff.grow_rate    <= peu_pkg::GROW_RATE_RST;
         cfg_ff.life_span    <= peu_pkg::LIFE_SPAN_RST;
         cfg_ff.stagger_step <= peu_pkg::STAGGER_STEP_RST;
         cfg_ff.rot_row0     <= peu_pkg::ROT_ROW0_RST;
         cfg_ff.rot_row1     <= peu_pkg::ROT_ROW1_RST;
         cfg_ff.rot_row2     <= peu_pkg::ROT_ROW2_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   peu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_step_time (req_step_time),
      .req_slot      (req_slot),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .q_out         (q),
      .q_pop         (q_pop)
   );

   peu_back #(.PARTICLES(PARTICLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_last  (rsp_last)
   );

   assign rsp_particle_id = rsp.id;
   assign rsp_out_x       = rsp.x;
   assign rsp_out_y       = rsp.y;
   assign rsp_out_z       = rsp.z;
   assign rsp_out_size    = rsp.size;
   assign rsp_alpha       = rsp.alpha;

endmodule

/* hw/rtl/peu_checker.sv */
// ----------------------------------------------------------------------------
// peu_checker
// Port-level checks of the particle emitter update block.
// ----------------------------------------------------------------------------
module peu_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last,
   input logic [7:0] rsp_alpha
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("result or busy right after reset");

   a_alpha_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha <= 8'd204)
      else $error("alpha above cap");

   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in adjacent cycles");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      busy && !start |=> busy || !$past(busy) || $fell(busy))
      else $error("busy state inconsistent");

   a_last_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last without result strobe");

endmodule

bind particle_emitter_update peu_checker u_peu_checker (.*);
